@@ sv/slnp_pkg.sv @@
// ----------------------------------------------------------------------------
// slnp_pkg
// Shared types and codes for the sorted list with node pool: operation kinds,
// result status codes, the command broadcast to the cell chain.
// ----------------------------------------------------------------------------
package slnp_pkg;

  localparam int VAL_W      = 32;
  localparam int POOL_W     = 5;
  localparam int CNT_OUT_W  = 5;
  localparam int POOL_RESET = 16;
  localparam int MAX_OUT    = 16;

  // operation kinds carried by an input transaction
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_DUMP   = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_POOL_EMPTY = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND  = 2'd2;
  localparam logic [1:0] STAT_LIST_EMPTY = 2'd3;

  // command broadcast to every cell
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_DEL_SCAN,
    CMD_DEL_COMMIT,
    CMD_ROTATE,
    CMD_CLEAR
  } cmd_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic signed [VAL_W-1:0]  key;
  } ctl_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_INS  = 5'b00010,
    ST_DEL  = 5'b00100,
    ST_DUMP = 5'b01000,
    ST_CLR  = 5'b10000
  } state_e;

endpackage

@@ sv/sorted_list_with_node_pool_core.sv @@
// ----------------------------------------------------------------------------
// sorted_list_with_node_pool_core
// Ascending list of signed values in a chain of NODES cells, capacity set by
// pool_size at reset and clear. Insert, delete, dump and clear operations.
// ----------------------------------------------------------------------------
// Sequence: insert and clear take one sequencer state, result registered; delete
//   scans while the match flag crosses the chain one cell per cycle, then commits.
// Dump: elements follow one per cycle; busy while the ring rotates once
//   through all NODES cells; an empty dump gives a single status result.
// Throughput: one transaction at a time; the next start is taken once busy
//   drops, in the cycle the final result is shown except after a dump of a
//   list shorter than NODES, which holds busy until the rotation ends.
//   The receiver cannot stall.
// Reset: list empty, pool size 16 clamped to NODES; no clearing pass.
module sorted_list_with_node_pool_core #(
  parameter int NODES = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic [1:0]                            kind_i,
  input  logic signed [slnp_pkg::VAL_W-1:0]     value_i,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [slnp_pkg::POOL_W-1:0]           cfg_pool_size_i,
  output logic                                  res_valid_o,
  output logic [1:0]                            status_o,
  output logic signed [slnp_pkg::VAL_W-1:0]     item_value_o,
  output logic [slnp_pkg::CNT_OUT_W-1:0]        used_count_o,
  output logic                                  last_o
);

  localparam int CW      = $clog2(NODES + 1);
  localparam int EFF_RST = (NODES < slnp_pkg::POOL_RESET) ? NODES : slnp_pkg::POOL_RESET;

  slnp_pkg::state_e                   state_q, state_d;
  logic [CW-1:0]                      step_q, step_d;
  logic [CW-1:0]                      used_q, used_d;
  logic [CW-1:0]                      eff_q, eff_d;
  logic [CW-1:0]                      eff_new;
  logic [slnp_pkg::POOL_W-1:0]        pool_q;
  logic signed [slnp_pkg::VAL_W-1:0]  key_q, key_d;
  slnp_pkg::cmd_e                     cmd;
  slnp_pkg::ctl_t                     ctl;

  logic                               rv_q, rv_d;
  logic [1:0]                         st_q, st_d;
  logic signed [slnp_pkg::VAL_W-1:0]  it_q, it_d;
  logic [slnp_pkg::CNT_OUT_W-1:0]     uc_q;
  logic                               last_q, last_d;

  logic signed [slnp_pkg::VAL_W-1:0]  val_w [NODES];
  logic                               occ_w [NODES];
  logic                               ge_w  [NODES];
  logic                               f_w   [NODES];

  assign ctl.cmd = cmd;
  assign ctl.key = key_q;

  // cell chain; the last cell wraps to the first for rotation
  for (genvar k = 0; k < NODES; k++) begin : g_cell
    logic signed [slnp_pkg::VAL_W-1:0] lv, rvl;
    logic                              lo, lg, lf, ro;
    if (k == 0) begin : g_first
      assign lv = '0;
      assign lo = 1'b0;
      assign lg = 1'b0;
      assign lf = 1'b0;
    end else begin : g_mid
      assign lv = val_w[k-1];
      assign lo = occ_w[k-1];
      assign lg = ge_w[k-1];
      assign lf = f_w[k-1];
    end
    if (k == NODES - 1) begin : g_last
      assign rvl = val_w[0];
      assign ro  = (cmd == slnp_pkg::CMD_ROTATE) ? occ_w[0] : 1'b0;
    end else begin : g_inner
      assign rvl = val_w[k+1];
      assign ro  = occ_w[k+1];
    end
    slnp_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .left_val_i  (lv),
      .left_occ_i  (lo),
      .left_ge_i   (lg),
      .left_f_i    (lf),
      .right_val_i (rvl),
      .right_occ_i (ro),
      .val_o       (val_w[k]),
      .occ_o       (occ_w[k]),
      .ge_o        (ge_w[k]),
      .f_o         (f_w[k])
    );
  end

  // clamp pool size into one to NODES
  always_comb begin
    if (pool_q == '0) begin
      eff_new = CW'(1);
    end else if (32'(pool_q) > NODES) begin
      eff_new = CW'(NODES);
    end else begin
      eff_new = CW'(pool_q);
    end
  end

  // sequence the operations and form the results
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    used_d  = used_q;
    eff_d   = eff_q;
    key_d   = key_q;
    cmd     = slnp_pkg::CMD_HOLD;
    rv_d    = 1'b0;
    st_d    = slnp_pkg::STAT_OK;
    it_d    = '0;
    last_d  = 1'b1;
    unique case (state_q)
      slnp_pkg::ST_IDLE: begin
        if (start_i) begin
          key_d  = value_i;
          step_d = '0;
          unique case (kind_i)
            slnp_pkg::KIND_INSERT: state_d = slnp_pkg::ST_INS;
            slnp_pkg::KIND_DELETE: state_d = slnp_pkg::ST_DEL;
            slnp_pkg::KIND_DUMP:   state_d = slnp_pkg::ST_DUMP;
            slnp_pkg::KIND_CLEAR:  state_d = slnp_pkg::ST_CLR;
            default:               state_d = slnp_pkg::ST_IDLE;
          endcase
        end
      end
      slnp_pkg::ST_INS: begin
        if (used_q == eff_q) begin
          st_d = slnp_pkg::STAT_POOL_EMPTY;
        end else begin
          cmd    = slnp_pkg::CMD_INSERT;
          used_d = used_q + CW'(1);
        end
        rv_d    = 1'b1;
        state_d = slnp_pkg::ST_IDLE;
      end
      slnp_pkg::ST_DEL: begin
        if (32'(step_q) < NODES) begin
          cmd    = slnp_pkg::CMD_DEL_SCAN;
          step_d = step_q + CW'(1);
        end else begin
          if (f_w[NODES-1]) begin
            cmd    = slnp_pkg::CMD_DEL_COMMIT;
            used_d = used_q - CW'(1);
          end else begin
            st_d = slnp_pkg::STAT_NOT_FOUND;
          end
          rv_d    = 1'b1;
          state_d = slnp_pkg::ST_IDLE;
        end
      end
      slnp_pkg::ST_DUMP: begin
        if (used_q == '0) begin
          st_d    = slnp_pkg::STAT_LIST_EMPTY;
          rv_d    = 1'b1;
          state_d = slnp_pkg::ST_IDLE;
        end else begin
          cmd = slnp_pkg::CMD_ROTATE;
          if ((32'(step_q) < 32'(used_q)) && (32'(step_q) < slnp_pkg::MAX_OUT)) begin
            rv_d   = 1'b1;
            it_d   = val_w[0];
            last_d = (32'(step_q) + 1 == 32'(used_q)) ||
                     (32'(step_q) + 1 == slnp_pkg::MAX_OUT);
          end
          if (32'(step_q) == NODES - 1) begin
            state_d = slnp_pkg::ST_IDLE;
          end
          step_d = step_q + CW'(1);
        end
      end
      slnp_pkg::ST_CLR: begin
        cmd     = slnp_pkg::CMD_CLEAR;
        used_d  = '0;
        eff_d   = eff_new;
        rv_d    = 1'b1;
        state_d = slnp_pkg::ST_IDLE;
      end
      default: begin
        state_d = slnp_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slnp_pkg::ST_IDLE;
      step_q  <= '0;
      used_q  <= '0;
      eff_q   <= CW'(EFF_RST);
      pool_q  <= slnp_pkg::POOL_W'(slnp_pkg::POOL_RESET);
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      used_q  <= used_d;
      eff_q   <= eff_d;
      rv_q    <= rv_d;
      if (cfg_valid_i) begin
        pool_q <= cfg_pool_size_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    st_q   <= st_d;
    it_q   <= it_d;
    uc_q   <= slnp_pkg::CNT_OUT_W'(used_d);
    last_q <= last_d;
  end

  assign busy_o       = (state_q != slnp_pkg::ST_IDLE);
  assign cfg_ready_o  = 1'b1;
  assign res_valid_o  = rv_q;
  assign status_o     = st_q;
  assign item_value_o = it_q;
  assign used_count_o = uc_q;
  assign last_o       = last_q;

endmodule

@@ sv/slnp_cell.sv @@
// ----------------------------------------------------------------------------
// slnp_cell
// One slot of the sorted chain: holds a value and an occupied flag, shifts
// right on insert, left on delete, rotates for dump and passes the delete
// match flag on to its right neighbor one slot per cycle.
// ----------------------------------------------------------------------------
module slnp_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  slnp_pkg::ctl_t                     ctl_i,
  input  logic signed [slnp_pkg::VAL_W-1:0]  left_val_i,
  input  logic                               left_occ_i,
  input  logic                               left_ge_i,
  input  logic                               left_f_i,
  input  logic signed [slnp_pkg::VAL_W-1:0]  right_val_i,
  input  logic                               right_occ_i,
  output logic signed [slnp_pkg::VAL_W-1:0]  val_o,
  output logic                               occ_o,
  output logic                               ge_o,
  output logic                               f_o
);

  logic signed [slnp_pkg::VAL_W-1:0] val_q, val_d;
  logic                              occ_q, occ_d;
  logic                              f_q, f_d;
  logic                              ge;
  logic                              hit;

  // slot at or past the key position: empty, or value not below the key
  assign ge  = !occ_q || (val_q >= ctl_i.key);
  // first slot at or past the key holds the key itself
  assign hit = ge && !left_ge_i && occ_q && (val_q == ctl_i.key);

  always_comb begin
    val_d = val_q;
    occ_d = occ_q;
    f_d   = 1'b0;
    unique case (ctl_i.cmd)
      slnp_pkg::CMD_HOLD: begin
      end
      slnp_pkg::CMD_INSERT: begin
        if (left_ge_i) begin
          val_d = left_val_i;
          occ_d = left_occ_i;
        end else if (ge) begin
          val_d = ctl_i.key;
          occ_d = 1'b1;
        end
      end
      slnp_pkg::CMD_DEL_SCAN: begin
        f_d = left_f_i || hit;
      end
      slnp_pkg::CMD_DEL_COMMIT: begin
        if (ge) begin
          val_d = right_val_i;
          occ_d = right_occ_i;
        end
      end
      slnp_pkg::CMD_ROTATE: begin
        val_d = right_val_i;
        occ_d = right_occ_i;
      end
      slnp_pkg::CMD_CLEAR: begin
        occ_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
      f_q   <= 1'b0;
    end else begin
      occ_q <= occ_d;
      f_q   <= f_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign occ_o = occ_q;
  assign ge_o  = ge;
  assign f_o   = f_q;

endmodule

@@ sv/slnp_checker.sv @@
// ----------------------------------------------------------------------------
// slnp_checker
// Port-level checks on the sorted list core: start handshake, result bursts
// and status consistency. Bound to the top level.
// ----------------------------------------------------------------------------
module slnp_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic                                  busy_o,
  input  logic                                  res_valid_o,
  input  logic [1:0]                            status_o,
  input  logic signed [slnp_pkg::VAL_W-1:0]     item_value_o,
  input  logic                                  last_o
);

  // an accepted transaction keeps the core busy in the next cycle
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("core not busy after accepted transaction");

  // a dump burst has no gaps until its final result
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !last_o) |=> res_valid_o)
    else $error("result burst broken before final result");

  // an empty dump reports one result with zero value
  a_empty_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && status_o == slnp_pkg::STAT_LIST_EMPTY) |->
      (last_o && item_value_o == '0))
    else $error("empty dump result malformed");

  // any failure status ends the transaction
  a_fail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && status_o != slnp_pkg::STAT_OK) |-> last_o)
    else $error("failure status not marked last");

  // a non-final result belongs to a burst still in progress
  a_burst_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !last_o) |-> busy_o)
    else $error("burst result while core idle");

endmodule

bind sorted_list_with_node_pool_core slnp_checker u_slnp_checker (.*);

@@ bench/tb_sorted_list_with_node_pool_core.sv @@
// ----------------------------------------------------------------------------
// tb_sorted_list_with_node_pool_core
// Self-checking bench for the sorted list core. A queue-based model of the
// ascending list and its node pool predicts every result. Directed, pool-size
// and random tests drive inserts, deletes, dumps and clears with random gaps.
// ----------------------------------------------------------------------------
module tb_sorted_list_with_node_pool_core;

  localparam int NODES      = 16;
  localparam int STALL_MAX  = 1000;
  localparam int INT_MIN    = 32'sh8000_0000;
  localparam int INT_MAX    = 32'sh7fff_ffff;

  typedef struct {
    logic [1:0]                         status;
    logic signed [slnp_pkg::VAL_W-1:0]  item_value;
    logic [slnp_pkg::CNT_OUT_W-1:0]     used_count;
    logic                               last;
  } list_result_t;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               start_i;
  logic                               busy_o;
  logic [1:0]                         kind_i;
  logic signed [slnp_pkg::VAL_W-1:0]  value_i;
  logic                               cfg_valid_i;
  logic                               cfg_ready_o;
  logic [slnp_pkg::POOL_W-1:0]        cfg_pool_size_i;
  logic                               res_valid_o;
  logic [1:0]                         status_o;
  logic signed [slnp_pkg::VAL_W-1:0]  item_value_o;
  logic [slnp_pkg::CNT_OUT_W-1:0]     used_count_o;
  logic                               last_o;

  // model state: list contents in order, pool size register, active capacity
  int            list_vals[$];
  int            pool_size_reg;
  int            pool_cap;
  list_result_t  pending_results[$];
  int            fail_count;
  int            stall_cycles;
  bit            steady_feed;

  sorted_list_with_node_pool_core #(
    .NODES(NODES)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .kind_i          (kind_i),
    .value_i         (value_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_pool_size_i (cfg_pool_size_i),
    .res_valid_o     (res_valid_o),
    .status_o        (status_o),
    .item_value_o    (item_value_o),
    .used_count_o    (used_count_o),
    .last_o          (last_o)
  );

  always #10 clk_i = ~clk_i;

  // clamp the pool size register to the usable range
  function automatic int clamp_pool(input int size);
    if (size < 1) return 1;
    if (size > NODES) return NODES;
    return size;
  endfunction

  // apply one operation to the list model and queue the results it causes
  task automatic predict_list_op(input logic [1:0] kind, input int value);
    int           pos;
    list_result_t r;
    r.status     = slnp_pkg::STAT_OK;
    r.item_value = '0;
    r.last       = 1'b1;
    case (kind)
      slnp_pkg::KIND_INSERT: begin
        if (list_vals.size() >= pool_cap) begin
          r.status = slnp_pkg::STAT_POOL_EMPTY;
        end else begin
          pos = 0;
          while (pos < list_vals.size() && list_vals[pos] < value) pos++;
          list_vals.insert(pos, value);
        end
      end
      slnp_pkg::KIND_DELETE: begin
        pos = 0;
        while (pos < list_vals.size() && list_vals[pos] != value) pos++;
        if (pos == list_vals.size()) r.status = slnp_pkg::STAT_NOT_FOUND;
        else list_vals.delete(pos);
      end
      slnp_pkg::KIND_DUMP: begin
        if (list_vals.size() == 0) r.status = slnp_pkg::STAT_LIST_EMPTY;
      end
      default: begin
        list_vals.delete();
        pool_cap = clamp_pool(pool_size_reg);
      end
    endcase
    r.used_count = slnp_pkg::CNT_OUT_W'(list_vals.size());
    // emit one element per result on a non-empty dump
    if (kind == slnp_pkg::KIND_DUMP && list_vals.size() != 0) begin
      for (pos = 0; pos < list_vals.size() && pos < slnp_pkg::MAX_OUT; pos++) begin
        r.item_value = list_vals[pos];
        r.last       = (pos == list_vals.size() - 1) || (pos == slnp_pkg::MAX_OUT - 1);
        pending_results.push_back(r);
      end
    end else begin
      pending_results.push_back(r);
    end
  endtask

  // send one command transaction after a random gap; call at a falling edge
  task automatic send_op(input logic [1:0] kind, input int value);
    int gap;
    gap = 0;
    if (!steady_feed) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: gap = 0;
        5, 6, 7, 8:    gap = $urandom_range(1, 3);
        default:       gap = $urandom_range(8, 30);
      endcase
    end
    if (gap != 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i = 1'b1;
    kind_i  = kind;
    value_i = value;
    do @(posedge clk_i); while (busy_o);
    predict_list_op(kind, value);
    @(negedge clk_i);
    start_i = 1'b0;
  endtask

  // hold the sender until every expected result has come
  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // drain, let a dump finish its rotation, then write the pool size
  task automatic write_pool_size(input int size);
    drain_results();
    repeat (NODES + 4) @(negedge clk_i);
    cfg_valid_i     = 1'b1;
    cfg_pool_size_i = slnp_pkg::POOL_W'(size);
    do @(posedge clk_i); while (!cfg_ready_o);
    pool_size_reg = size;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // mostly small values for duplicates and hits, some extremes and full range
  function automatic int pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 20) - 10;
      6: begin
        if (list_vals.size() != 0)
          return list_vals[$urandom_range(0, list_vals.size() - 1)];
        return $urandom_range(0, 3);
      end
      7: begin
        case ($urandom_range(0, 3))
          0: return INT_MIN;
          1: return INT_MAX;
          2: return INT_MIN + 1;
          default: return INT_MAX - 1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed_ops();
    send_op(slnp_pkg::KIND_DUMP,   0);
    send_op(slnp_pkg::KIND_DELETE, 5);
    send_op(slnp_pkg::KIND_INSERT, INT_MAX);
    send_op(slnp_pkg::KIND_INSERT, INT_MIN);
    send_op(slnp_pkg::KIND_INSERT, 0);
    send_op(slnp_pkg::KIND_INSERT, 0);
    send_op(slnp_pkg::KIND_INSERT, -1);
    send_op(slnp_pkg::KIND_DUMP,   0);
    send_op(slnp_pkg::KIND_DELETE, 0);
    send_op(slnp_pkg::KIND_DELETE, 7);
    send_op(slnp_pkg::KIND_DELETE, INT_MIN);
    send_op(slnp_pkg::KIND_DELETE, INT_MAX);
    send_op(slnp_pkg::KIND_DUMP,   0);
    send_op(slnp_pkg::KIND_CLEAR,  0);
    send_op(slnp_pkg::KIND_DUMP,   0);
    // new pool size waits for the next clear
    write_pool_size(1);
    send_op(slnp_pkg::KIND_INSERT, 3);
    send_op(slnp_pkg::KIND_INSERT, 4);
    send_op(slnp_pkg::KIND_CLEAR,  0);
    send_op(slnp_pkg::KIND_INSERT, 9);
    send_op(slnp_pkg::KIND_INSERT, 10);
    send_op(slnp_pkg::KIND_DUMP,   0);
    send_op(slnp_pkg::KIND_DELETE, 9);
    send_op(slnp_pkg::KIND_INSERT, 10);
  endtask

  // fill each pool past its capacity, including out-of-range sizes
  task automatic test_pool_limits();
    int sizes[5];
    int n;
    sizes = '{0, 31, 17, 2, 1};
    foreach (sizes[k]) begin
      write_pool_size(sizes[k]);
      send_op(slnp_pkg::KIND_CLEAR, $urandom);
      for (n = 0; n <= clamp_pool(sizes[k]); n++) begin
        send_op(slnp_pkg::KIND_INSERT, pick_value());
      end
      send_op(slnp_pkg::KIND_DUMP, $urandom);
      send_op(slnp_pkg::KIND_DELETE, list_vals[list_vals.size() - 1]);
      // a one-node pool is empty again here; delete a random value instead
      send_op(slnp_pkg::KIND_DELETE, (list_vals.size() != 0) ? list_vals[0] : pick_value());
    end
  endtask

  task automatic test_random_ops(input int phases, input int per_phase);
    int n;
    int v;
    for (int p = 0; p < phases; p++) begin
      steady_feed = ($urandom_range(0, 3) == 0);
      // resize the pool between phases, mostly with a clear to apply it
      if (p != 0 && $urandom_range(0, 2) != 0) begin
        write_pool_size($urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(1, 5));
        if ($urandom_range(0, 3) != 0) send_op(slnp_pkg::KIND_CLEAR, $urandom);
      end
      for (n = 0; n < per_phase; n++) begin
        if ($urandom_range(0, 39) == 0) drain_results();
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8: send_op(slnp_pkg::KIND_INSERT, pick_value());
          9, 10, 11, 12, 13, 14: begin
            v = pick_value();
            if (list_vals.size() != 0 && $urandom_range(0, 9) < 7)
              v = list_vals[$urandom_range(0, list_vals.size() - 1)];
            send_op(slnp_pkg::KIND_DELETE, v);
          end
          15, 16, 17, 18: send_op(slnp_pkg::KIND_DUMP, $urandom);
          default: send_op(slnp_pkg::KIND_CLEAR, $urandom);
        endcase
      end
    end
    steady_feed = 1'b0;
  endtask

  // compare each result with the oldest expectation
  always @(posedge clk_i) begin
    list_result_t exp_r;
    if (rst_ni && res_valid_o) begin
      if (pending_results.size() == 0) begin
        $error("result with no pending transaction");
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, status_o);
          fail_count++;
        end
        if (item_value_o !== exp_r.item_value) begin
          $error("item_value: expected %0d, actual %0d", exp_r.item_value, item_value_o);
          fail_count++;
        end
        if (used_count_o !== exp_r.used_count) begin
          $error("used_count: expected %0d, actual %0d", exp_r.used_count, used_count_o);
          fail_count++;
        end
        if (last_o !== exp_r.last) begin
          $error("last: expected %0d, actual %0d", exp_r.last, last_o);
          fail_count++;
        end
      end
    end
  end

  // end the run when nothing is accepted for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || res_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    kind_i          = slnp_pkg::KIND_INSERT;
    value_i         = '0;
    cfg_valid_i     = 1'b0;
    cfg_pool_size_i = '0;
    fail_count      = 0;
    stall_cycles    = 0;
    steady_feed     = 1'b0;
    pool_size_reg   = slnp_pkg::POOL_RESET;
    pool_cap        = clamp_pool(slnp_pkg::POOL_RESET);

    // hold reset, then release it at a falling edge
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_ops();
    test_pool_limits();
    test_random_ops(8, 46);

    drain_results();
    repeat (NODES + 4) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
